// File: sv/json_syntax_validator_assert.svh
// Assertion macros for the JSON syntax validator.
`ifndef JSON_SYNTAX_VALIDATOR_ASSERT_SVH
`define JSON_SYNTAX_VALIDATOR_ASSERT_SVH

// check a condition at every clock edge out of reset
`define JSV_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// check that a trigger implies a condition in the same cycle
`define JSV_ASSERT_IMPL(lbl, trig, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (expr)) \
    else $error(msg);

`endif

// File: sv/jsv_pkg.sv
// Shared types, codes and character helpers of the JSON syntax validator.
package jsv_pkg;

  typedef enum logic [3:0] {
    R_NONE           = 4'd0,
    R_BAD_VALUE      = 4'd1,
    R_UNTERM_STRING  = 4'd2,
    R_BAD_ESCAPE     = 4'd3,
    R_CONTROL        = 4'd4,
    R_BAD_KEY        = 4'd5,
    R_UNTERM_OBJECT  = 4'd6,
    R_UNTERM_ARRAY   = 4'd7,
    R_TRAILING_COMMA = 4'd8,
    R_MISSING_COMMA  = 4'd9,
    R_MISSING_COLON  = 4'd10,
    R_DEPTH          = 4'd11
  } reason_t;

  typedef enum logic [4:0] {
    M_VALUE     = 5'd0,
    M_ARR_FIRST = 5'd1,
    M_ARR_COMMA = 5'd2,
    M_ARR_AFTER = 5'd3,
    M_OBJ_FIRST = 5'd4,
    M_OBJ_COMMA = 5'd5,
    M_OBJ_AFTER = 5'd6,
    M_COLON     = 5'd7,
    M_STR       = 5'd8,
    M_ESC       = 5'd9,
    M_HEX1      = 5'd10,
    M_PAIR      = 5'd11,
    M_LIT       = 5'd12,
    M_NUM_SIGN  = 5'd13,
    M_NUM_ZERO  = 5'd14,
    M_NUM_INT   = 5'd15,
    M_NUM_DOT   = 5'd16,
    M_NUM_FRAC  = 5'd17,
    M_NUM_E     = 5'd18,
    M_NUM_ESIGN = 5'd19,
    M_NUM_EXP   = 5'd20
  } mode_t;

  localparam logic [1:0] LIT_TRUE  = 2'd0;
  localparam logic [1:0] LIT_FALSE = 2'd1;
  localparam logic [1:0] LIT_NULL  = 2'd2;

  localparam logic       KIND_OBJECT = 1'b0;
  localparam logic       KIND_ARRAY  = 1'b1;

  localparam logic [15:0] KEY_LEN_RESET = 16'd256;
  localparam logic [2:0]  CFG_MAX_KEY   = 3'd0;
  localparam logic [15:0] HI_SUR_LO     = 16'hD800;
  localparam logic [15:0] HI_SUR_HI     = 16'hDBFF;
  localparam logic [15:0] LO_SUR_LO     = 16'hDC00;
  localparam logic [15:0] LO_SUR_HI     = 16'hDFFF;
  localparam logic [7:0]  CTRL_LIMIT    = 8'h20;

  typedef struct packed {
    logic [7:0] byte_req;
    logic       last;
    logic       starts_document;
  } in_item_t;

  typedef struct packed {
    logic        failed;
    reason_t     reason;
    logic [20:0] end_offset;
  } out_item_t;

  typedef struct packed {
    mode_t       mode;
    logic        top;
    logic [16:0] slen;
    logic [15:0] hex;
    logic [2:0]  sub;
    logic        fin;
    logic        key;
    logic [1:0]  lit;
    logic        flt;
  } st_t;

  localparam st_t ST_RESET = '{mode: M_VALUE, top: 1'b0, slen: 17'd0, hex: 16'd0,
                               sub: 3'd0, fin: 1'b0, key: 1'b0, lit: 2'd0, flt: 1'b0};

  function automatic logic is_ws(input logic [7:0] c);
    return (c == 8'h20) || (c == 8'h09) || (c == 8'h0A) || (c == 8'h0D);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic [4:0] hexval(input logic [7:0] c);
    logic [7:0] v;
    v = 8'd16;
    if (is_digit(c)) v = c - 8'h30;
    else if (c >= "a" && c <= "f") v = c - 8'h57;
    else if (c >= "A" && c <= "F") v = c - 8'h37;
    return v[4:0];
  endfunction

  function automatic logic [2:0] lit_len(input logic [1:0] k);
    return (k == LIT_FALSE) ? 3'd5 : 3'd4;
  endfunction

  function automatic logic [7:0] lit_char(input logic [1:0] k, input logic [2:0] i);
    logic [39:0] s;
    unique case (k)
      LIT_TRUE:  s = {"true", 8'h00};
      LIT_FALSE: s = "false";
      LIT_NULL:  s = {"null", 8'h00};
      default:   s = '0;
    endcase
    unique case (i)
      3'd0:    return s[39:32];
      3'd1:    return s[31:24];
      3'd2:    return s[23:16];
      3'd3:    return s[15:8];
      3'd4:    return s[7:0];
      default: return 8'h00;
    endcase
  endfunction

endpackage

// File: sv/jsv_ram.sv
// Generic single-port-write, registered-read RAM.
module jsv_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 65,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/jsv_cfg.sv
// APB register block holding the key length limit.
module jsv_cfg import jsv_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [15:0] max_key
);

  logic [15:0] max_key_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_key_r <= KEY_LEN_RESET;
    end else if (psel && penable && pwrite && paddr == CFG_MAX_KEY) begin
      max_key_r <= pwdata[15:0];
    end
  end

  assign pready  = 1'b1;
  assign prdata  = (paddr == CFG_MAX_KEY) ? {16'd0, max_key_r} : 32'd0;
  assign max_key = max_key_r;

endmodule

// File: sv/jsv_step.sv
// Per-byte next-state logic of the JSON parser.
module jsv_step import jsv_pkg::*; #(
  parameter int MAX_DEPTH = 64,
  parameter int MAX_BYTES = 1048576,
  localparam int DW = $clog2(MAX_DEPTH + 2),
  localparam int PW = $clog2(MAX_BYTES + 1)
) (
  input  st_t           cur,
  input  logic [DW-1:0] depth,
  input  logic [PW-1:0] pos,
  input  logic [PW-1:0] tok,
  input  logic [PW-1:0] fpos,
  input  logic          rd_kind,
  input  logic [7:0]    c,
  input  logic          last,
  input  logic [15:0]   max_key,
  output st_t           nxt,
  output logic [DW-1:0] d_nxt,
  output logic [PW-1:0] p_nxt,
  output logic [PW-1:0] tok_nxt,
  output logic [PW-1:0] fp_nxt,
  output logic          push,
  output logic          push_kind,
  output logic          pop,
  output logic          res_v,
  output reason_t       res_reason,
  output logic [PW-1:0] res_off
);

  localparam logic [DW-1:0] DMAX = DW'(MAX_DEPTH);
  localparam logic [PW-1:0] PMAX = PW'(MAX_BYTES);

  logic          full;
  logic [PW-1:0] pos1;
  logic [4:0]    h;
  logic [16:0]   key_lim;
  logic          num_end;
  logic          run_after;
  logic          close;
  logic          sv;
  logic          elem;

  assign full    = pos >= PMAX;
  assign pos1    = pos + PW'(1);
  assign h       = hexval(c);
  assign key_lim = {1'b0, max_key};

  always_comb begin
    nxt = cur; d_nxt = depth; p_nxt = pos; tok_nxt = tok; fp_nxt = fpos;
    push = 1'b0; push_kind = KIND_OBJECT; pop = 1'b0;
    res_v = 1'b0; res_reason = R_NONE; res_off = '0;
    num_end = 1'b0; run_after = 1'b0; close = 1'b0; sv = 1'b0; elem = 1'b0;
    if (!cur.fin) begin
      if (!full) begin
        unique case (cur.mode)
          M_VALUE: begin
            if (!is_ws(c)) sv = 1'b1;
          end
          M_ARR_FIRST: begin
            if (c == "]") close = 1'b1;
            else if (!is_ws(c)) begin sv = 1'b1; elem = 1'b1; end
          end
          M_ARR_COMMA: begin
            if (c == "]") begin res_v = 1'b1; res_reason = R_TRAILING_COMMA; res_off = pos; end
            else if (!is_ws(c)) begin sv = 1'b1; elem = 1'b1; end
          end
          M_ARR_AFTER, M_OBJ_AFTER: run_after = 1'b1;
          M_OBJ_FIRST, M_OBJ_COMMA: begin
            if (c == "}") begin
              if (cur.mode == M_OBJ_FIRST) close = 1'b1;
              else begin res_v = 1'b1; res_reason = R_TRAILING_COMMA; res_off = pos; end
            end else if (c == "\"") begin
              nxt.key = 1'b1; nxt.slen = '0; nxt.mode = M_STR;
            end else if (!is_ws(c)) begin
              res_v = 1'b1; res_reason = R_BAD_KEY; res_off = pos;
            end
          end
          M_COLON: begin
            if (c == ":") begin
              if (depth > DMAX) begin res_v = 1'b1; res_reason = R_DEPTH; res_off = pos1; end
              else nxt.mode = M_VALUE;
            end else if (!is_ws(c)) begin
              res_v = 1'b1; res_reason = R_MISSING_COLON; res_off = pos;
            end
          end
          M_STR: begin
            if (c == "\"") begin
              if (cur.key) nxt.mode = M_COLON;
              else if (depth == '0) begin res_v = 1'b1; res_reason = R_NONE; res_off = pos1; end
              else nxt.mode = cur.top ? M_ARR_AFTER : M_OBJ_AFTER;
            end else if (c < CTRL_LIMIT) begin
              res_v = 1'b1; res_reason = R_CONTROL; res_off = pos;
            end else if (c == "\\") begin
              nxt.mode = M_ESC;
            end else if (cur.key) begin
              nxt.slen = cur.slen + 17'd1;
              if (nxt.slen > key_lim) begin
                res_v = 1'b1; res_reason = R_BAD_VALUE; res_off = pos1;
              end
            end
          end
          M_ESC: begin
            if (c == "\"" || c == "\\" || c == "/" || c == "b" || c == "f" ||
                c == "n" || c == "r" || c == "t") begin
              nxt.mode = M_STR;
              if (cur.key) begin
                nxt.slen = cur.slen + 17'd1;
                if (nxt.slen > key_lim) begin
                  res_v = 1'b1; res_reason = R_BAD_VALUE; res_off = pos1;
                end
              end
            end else if (c == "u") begin
              tok_nxt = pos; nxt.sub = '0; nxt.hex = '0; nxt.flt = 1'b0; nxt.mode = M_HEX1;
            end else begin
              res_v = 1'b1; res_reason = R_BAD_ESCAPE; res_off = pos;
            end
          end
          M_HEX1: begin
            if (h[4] && !cur.flt) begin nxt.flt = 1'b1; fp_nxt = pos; end
            nxt.hex = {cur.hex[11:0], h[3:0]};
            nxt.sub = cur.sub + 3'd1;
            if (nxt.sub >= 3'd4) begin
              if (nxt.flt) begin
                res_v = 1'b1; res_reason = R_BAD_ESCAPE; res_off = fp_nxt;
              end else begin
                if (cur.key) nxt.slen = cur.slen + 17'd1;
                if (nxt.hex >= HI_SUR_LO && nxt.hex <= HI_SUR_HI) begin
                  tok_nxt = pos1; nxt.sub = '0; nxt.hex = '0; nxt.mode = M_PAIR;
                end else if (nxt.hex >= LO_SUR_LO && nxt.hex <= LO_SUR_HI) begin
                  res_v = 1'b1; res_reason = R_BAD_ESCAPE; res_off = pos1;
                end else if (cur.key && nxt.slen > key_lim) begin
                  res_v = 1'b1; res_reason = R_BAD_VALUE; res_off = pos1;
                end else begin
                  nxt.mode = M_STR;
                end
              end
            end
          end
          M_PAIR: begin
            if (cur.sub < 3'd2) begin
              if (c != ((cur.sub == 3'd0) ? 8'h5C : 8'h75) && !cur.flt) begin
                nxt.flt = 1'b1; fp_nxt = tok;
              end
            end else begin
              if (h[4] && !cur.flt) begin nxt.flt = 1'b1; fp_nxt = pos; end
              nxt.hex = {cur.hex[11:0], h[3:0]};
            end
            nxt.sub = cur.sub + 3'd1;
            if (nxt.sub >= 3'd6) begin
              if (nxt.flt) begin
                res_v = 1'b1; res_reason = R_BAD_ESCAPE; res_off = fp_nxt;
              end else if (nxt.hex < LO_SUR_LO || nxt.hex > LO_SUR_HI) begin
                res_v = 1'b1; res_reason = R_BAD_ESCAPE; res_off = tok;
              end else begin
                nxt.mode = M_STR;
                if (cur.key) begin
                  nxt.slen = cur.slen + 17'd1;
                  if (nxt.slen > key_lim) begin
                    res_v = 1'b1; res_reason = R_BAD_VALUE; res_off = pos1;
                  end
                end
              end
            end
          end
          M_LIT: begin
            if (cur.sub < lit_len(cur.lit) && c == lit_char(cur.lit, cur.sub)) begin
              nxt.sub = cur.sub + 3'd1;
              if (nxt.sub == lit_len(cur.lit)) begin
                if (depth == '0) begin res_v = 1'b1; res_reason = R_NONE; res_off = pos1; end
                else nxt.mode = cur.top ? M_ARR_AFTER : M_OBJ_AFTER;
              end
            end else begin
              res_v = 1'b1; res_reason = R_BAD_VALUE; res_off = tok;
            end
          end
          M_NUM_SIGN: begin
            if (c == "0") nxt.mode = M_NUM_ZERO;
            else if (is_digit(c)) nxt.mode = M_NUM_INT;
            else begin res_v = 1'b1; res_reason = R_BAD_VALUE; res_off = tok; end
          end
          M_NUM_ZERO, M_NUM_INT: begin
            if (cur.mode == M_NUM_INT && is_digit(c)) nxt.mode = M_NUM_INT;
            else if (c == ".") nxt.mode = M_NUM_DOT;
            else if (c == "e" || c == "E") nxt.mode = M_NUM_E;
            else num_end = 1'b1;
          end
          M_NUM_DOT: begin
            if (is_digit(c)) nxt.mode = M_NUM_FRAC;
            else begin res_v = 1'b1; res_reason = R_BAD_VALUE; res_off = tok; end
          end
          M_NUM_FRAC: begin
            if (is_digit(c)) nxt.mode = M_NUM_FRAC;
            else if (c == "e" || c == "E") nxt.mode = M_NUM_E;
            else num_end = 1'b1;
          end
          M_NUM_E: begin
            if (c == "+" || c == "-") nxt.mode = M_NUM_ESIGN;
            else if (is_digit(c)) nxt.mode = M_NUM_EXP;
            else begin res_v = 1'b1; res_reason = R_BAD_VALUE; res_off = tok; end
          end
          M_NUM_ESIGN: begin
            if (is_digit(c)) nxt.mode = M_NUM_EXP;
            else begin res_v = 1'b1; res_reason = R_BAD_VALUE; res_off = tok; end
          end
          M_NUM_EXP: begin
            if (!is_digit(c)) num_end = 1'b1;
          end
          default: begin
            res_v = 1'b1; res_reason = R_BAD_VALUE; res_off = pos;
          end
        endcase

        // a number ends on the byte after it; that byte is then parsed again
        if (num_end) begin
          if (depth == '0) begin res_v = 1'b1; res_reason = R_NONE; res_off = pos; end
          else begin
            nxt.mode = cur.top ? M_ARR_AFTER : M_OBJ_AFTER;
            run_after = 1'b1;
          end
        end

        if (run_after) begin
          if (c == ",") nxt.mode = (nxt.mode == M_ARR_AFTER) ? M_ARR_COMMA : M_OBJ_COMMA;
          else if ((nxt.mode == M_ARR_AFTER && c == "]") ||
                   (nxt.mode == M_OBJ_AFTER && c == "}")) close = 1'b1;
          else if (!is_ws(c)) begin
            res_v = 1'b1; res_reason = R_MISSING_COMMA; res_off = pos;
          end
        end

        if (close) begin
          d_nxt = depth - DW'(1);
          pop = 1'b1;
          nxt.top = rd_kind;
          if (d_nxt == '0) begin res_v = 1'b1; res_reason = R_NONE; res_off = pos1; end
          else nxt.mode = rd_kind ? M_ARR_AFTER : M_OBJ_AFTER;
        end

        if (sv) begin
          if ((elem || c == "{" || c == "[") && depth > DMAX) begin
            res_v = 1'b1; res_reason = R_DEPTH; res_off = pos;
          end else if (c == "{" || c == "[") begin
            push = 1'b1;
            push_kind = (c == "[") ? KIND_ARRAY : KIND_OBJECT;
            d_nxt = depth + DW'(1);
            nxt.top = push_kind;
            nxt.mode = (c == "[") ? M_ARR_FIRST : M_OBJ_FIRST;
          end else if (c == "\"") begin
            nxt.key = 1'b0; nxt.mode = M_STR;
          end else if (c == "t" || c == "f" || c == "n") begin
            nxt.lit = (c == "t") ? LIT_TRUE : ((c == "f") ? LIT_FALSE : LIT_NULL);
            nxt.sub = 3'd1; tok_nxt = pos; nxt.mode = M_LIT;
          end else if (c == "-" || is_digit(c)) begin
            tok_nxt = pos;
            nxt.mode = (c == "-") ? M_NUM_SIGN : ((c == "0") ? M_NUM_ZERO : M_NUM_INT);
          end else begin
            res_v = 1'b1; res_reason = R_BAD_VALUE; res_off = pos;
          end
        end

        p_nxt = pos1;
      end

      // end of buffer: report what the open construct lacks, or success for a number that ends the document
      if ((full || last) && !res_v) begin
        res_v = 1'b1;
        res_off = p_nxt;
        unique case (nxt.mode)
          M_VALUE: res_reason = R_BAD_VALUE;
          M_ARR_FIRST, M_ARR_COMMA, M_ARR_AFTER: res_reason = R_UNTERM_ARRAY;
          M_OBJ_FIRST, M_OBJ_COMMA, M_OBJ_AFTER: res_reason = R_UNTERM_OBJECT;
          M_COLON: res_reason = R_MISSING_COLON;
          M_STR, M_ESC, M_HEX1: res_reason = R_UNTERM_STRING;
          M_PAIR: begin res_reason = R_BAD_ESCAPE; res_off = tok_nxt; end
          M_NUM_ZERO, M_NUM_INT, M_NUM_FRAC, M_NUM_EXP: begin
            if (d_nxt == '0) res_reason = R_NONE;
            else res_reason = nxt.top ? R_UNTERM_ARRAY : R_UNTERM_OBJECT;
          end
          default: begin res_reason = R_BAD_VALUE; res_off = tok_nxt; end
        endcase
      end
      if (res_v) nxt.fin = 1'b1;
    end
  end

endmodule

// File: sv/json_syntax_validator.sv
// Top level of the streaming JSON syntax validator.
// The block takes one byte per cycle unless the input is stalled, and gives one result per
// document: success with the offset after the value, or the first error with its offset. A
// result is registered and appears on the output, or waits in a skid register while the output
// holds an earlier one that is stalled; only while that register is full is the input stalled.
// The rate is set by the parse-state update: the kind of the innermost open container is
// kept in a register, the container stack lives in a RAM with a registered read, and the entry
// below the top is prefetched every cycle so a closing bracket needs no wait. The stack needs
// no clearing after reset or between documents.
`include "json_syntax_validator_assert.svh"
module json_syntax_validator import jsv_pkg::*; #(
  parameter int MAX_DEPTH = 64,
  parameter int MAX_BYTES = 1048576
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int DW = $clog2(MAX_DEPTH + 2);
  localparam int PW = $clog2(MAX_BYTES + 1);
  localparam int SD = MAX_DEPTH + 1;
  localparam int AW = $clog2(SD);

  logic [15:0]   max_key;
  st_t           st_r, st_eff, st_nxt;
  logic [DW-1:0] depth_r, depth_eff, depth_nxt, depth_sel;
  logic [PW-1:0] pos_r, pos_eff, pos_nxt;
  logic [PW-1:0] tok_r, tok_eff, tok_nxt;
  logic [PW-1:0] fpos_r, fpos_eff, fpos_nxt;
  logic          rd_kind;
  logic          push, push_kind, pop;
  logic          res_v;
  reason_t       res_reason;
  logic [PW-1:0] res_off;
  logic          acc;
  logic          out_fire;
  out_item_t     res_item;
  out_item_t     out_r, skid_r;
  logic          out_v_r, skid_v_r;

  jsv_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .max_key (max_key)
  );

  assign acc      = in_valid && !in_stall;
  assign in_stall = skid_v_r;

  // restart the document on its first byte
  assign st_eff    = in_data.starts_document ? ST_RESET : st_r;
  assign depth_eff = in_data.starts_document ? '0 : depth_r;
  assign pos_eff   = in_data.starts_document ? '0 : pos_r;
  assign tok_eff   = in_data.starts_document ? '0 : tok_r;
  assign fpos_eff  = in_data.starts_document ? '0 : fpos_r;

  jsv_step #(
    .MAX_DEPTH (MAX_DEPTH),
    .MAX_BYTES (MAX_BYTES)
  ) u_step (
    .cur        (st_eff),
    .depth      (depth_eff),
    .pos        (pos_eff),
    .tok        (tok_eff),
    .fpos       (fpos_eff),
    .rd_kind    (rd_kind),
    .c          (in_data.byte_req),
    .last       (in_data.last),
    .max_key    (max_key),
    .nxt        (st_nxt),
    .d_nxt      (depth_nxt),
    .p_nxt      (pos_nxt),
    .tok_nxt    (tok_nxt),
    .fp_nxt     (fpos_nxt),
    .push       (push),
    .push_kind  (push_kind),
    .pop        (pop),
    .res_v      (res_v),
    .res_reason (res_reason),
    .res_off    (res_off)
  );

  // prefetch the entry below the next top of stack
  assign depth_sel = acc ? depth_nxt : depth_r;

  jsv_ram #(
    .WIDTH (1),
    .DEPTH (SD)
  ) u_stack (
    .clk   (clk),
    .we    (acc && push),
    .waddr (AW'(depth_eff)),
    .wdata (push_kind),
    .raddr (AW'(depth_sel - DW'(2))),
    .rdata (rd_kind)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= ST_RESET;
      depth_r <= '0;
      pos_r   <= '0;
      tok_r   <= '0;
      fpos_r  <= '0;
    end else if (acc) begin
      st_r    <= st_nxt;
      depth_r <= depth_nxt;
      pos_r   <= pos_nxt;
      tok_r   <= tok_nxt;
      fpos_r  <= fpos_nxt;
    end
  end

  assign res_item = '{failed: (res_reason != R_NONE), reason: res_reason,
                      end_offset: 21'(res_off)};
  assign out_fire = out_v_r && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (out_fire) begin
        skid_v_r <= 1'b0;
      end
    end else if (acc && res_v) begin
      if (out_v_r && !out_fire) skid_v_r <= 1'b1;
      else out_v_r <= 1'b1;
    end else if (out_fire) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (out_fire) out_r <= skid_r;
    end else if (acc && res_v) begin
      if (out_v_r && !out_fire) skid_r <= res_item;
      else out_r <= res_item;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

  `JSV_ASSERT_IMPL(a_skid_needs_out, skid_v_r, out_v_r, "skid holds an item while output is empty")
  `JSV_ASSERT_ALWAYS(a_depth_bound, depth_r <= DW'(MAX_DEPTH + 1), "stack depth out of range")
  `JSV_ASSERT_IMPL(a_fail_flag, out_v_r, out_r.failed == (out_r.reason != R_NONE), "bad fail flag")
  `JSV_ASSERT_IMPL(a_push_pop, acc, !(push && pop), "push and pop in one item")

endmodule
